// ----- design/base64_stream_codec_assert.svh -----
// ----------------------------------------------------------------------------
// base64_stream_codec_assert.svh
// Assertion macros for the base64 stream codec, clocked on clk_i, off in reset.
// ----------------------------------------------------------------------------
`ifndef BASE64_STREAM_CODEC_ASSERT_SVH
`define BASE64_STREAM_CODEC_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define B64SC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define B64SC_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define B64SC_ASSERT(label, prop, msg)
`define B64SC_NEVER(label, cond, msg)
`endif

`endif

// ----- design/b64sc_pkg.sv -----
// ----------------------------------------------------------------------------
// b64sc_pkg
// Shared types, constants and alphabet functions of the base64 stream codec.
// ----------------------------------------------------------------------------
package b64sc_pkg;

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam logic [7:0]  PAD_CHAR    = 8'd61;

  typedef enum logic [1:0] {
    JOB_ENC,
    JOB_DEC,
    JOB_ERR
  } job_kind_e;

  // one group to be sent: up to four result items
  typedef struct packed {
    job_kind_e   kind;
    logic        last;
    logic [1:0]  npad;
    logic [1:0]  last_idx;
    logic [23:0] bits;
  } job_t;

  function automatic logic [7:0] b64_char(input logic [5:0] s);
    logic [7:0] w;
    logic [7:0] r;
    w = {2'b00, s};
    if (s < 6'd26) begin
      r = 8'd65 + w;
    end else if (s < 6'd52) begin
      r = 8'd71 + w;
    end else if (s < 6'd62) begin
      r = w - 8'd4;
    end else if (s == 6'd62) begin
      r = 8'd43;
    end else begin
      r = 8'd47;
    end
    return r;
  endfunction

  // {valid, sextet}
  function automatic logic [6:0] b64_sextet(input logic [7:0] c);
    logic [6:0] r;
    if (c inside {[8'd65:8'd90]}) begin
      r = {1'b1, 6'(c - 8'd65)};
    end else if (c inside {[8'd97:8'd122]}) begin
      r = {1'b1, 6'(c - 8'd71)};
    end else if (c inside {[8'd48:8'd57]}) begin
      r = {1'b1, 6'(c + 8'd4)};
    end else if (c == 8'd43) begin
      r = {1'b1, 6'd62};
    end else if (c == 8'd47) begin
      r = {1'b1, 6'd63};
    end else begin
      r = 7'd0;
    end
    return r;
  endfunction

endpackage

// ----- design/b64sc_front.sv -----
// ----------------------------------------------------------------------------
// b64sc_front
// Takes input items, gathers groups and hands finished groups on as jobs.
// ----------------------------------------------------------------------------
module b64sc_front
  import b64sc_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       decode_mode_i,
  input  logic       clear_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] in_value_i,
  input  logic       in_last_i,
  input  logic       q_full_i,
  output logic       job_push_o,
  output job_t       job_o
);

  logic [23:0] buf_q, buf_d;
  logic [1:0]  fill_q, fill_d;
  logic [1:0]  pad_q, pad_d;
  logic        err_q, err_d;

  logic       accept;
  logic [6:0] sx;
  logic       is_pad;
  logic       done;
  logic [5:0] sym;
  logic [1:0] fill_inc;
  logic [23:0] ebuf;
  logic [23:0] dbuf;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && !q_full_i;
  assign sx         = b64_sextet(in_value_i);
  assign is_pad     = (in_value_i == PAD_CHAR);
  assign done       = (fill_q == 2'd3);
  assign fill_inc   = fill_q + 2'd1;
  assign ebuf       = {buf_q[15:0], in_value_i};

  always_comb begin
    buf_d      = buf_q;
    fill_d     = fill_q;
    pad_d      = pad_q;
    err_d      = err_q;
    sym        = 6'd0;
    dbuf       = buf_q;
    job_push_o = 1'b0;
    job_o      = '{kind: JOB_ENC, last: in_last_i, npad: 2'd0, last_idx: 2'd3, bits: ebuf};
    if (clear_i) begin
      buf_d  = '0;
      fill_d = '0;
      pad_d  = '0;
      err_d  = 1'b0;
    end else if (accept) begin
      if (!decode_mode_i) begin
        buf_d  = ebuf;
        fill_d = fill_inc;
        if (fill_inc == 2'd3) begin
          job_push_o = 1'b1;
          buf_d      = '0;
          fill_d     = '0;
        end else if (in_last_i) begin
          job_push_o = 1'b1;
          if (fill_inc == 2'd1) begin
            job_o.bits = {ebuf[7:0], 16'd0};
            job_o.npad = 2'd2;
          end else begin
            job_o.bits = {ebuf[15:0], 8'd0};
            job_o.npad = 2'd1;
          end
          buf_d  = '0;
          fill_d = '0;
        end
      end else begin
        if (is_pad) begin
          if (fill_q < 2'd2) begin
            err_d = 1'b1;
          end else if (fill_q == 2'd2) begin
            pad_d = pad_q | 2'b10;
          end else begin
            pad_d = pad_q | 2'b01;
          end
        end else if (!sx[6] || pad_q != 2'b00) begin
          err_d = 1'b1;
        end else begin
          sym = sx[5:0];
        end
        dbuf = {buf_q[17:0], sym};
        if (done && pad_d != 2'b00 && !in_last_i) begin
          err_d = 1'b1;
        end
        if (in_last_i && !done) begin
          err_d = 1'b1;
        end
        job_o.bits     = dbuf;
        job_o.kind     = JOB_DEC;
        job_o.last_idx = 2'd2 - {1'b0, pad_d[0]} - {1'b0, pad_d[1]};
        if (err_d) begin
          fill_d = fill_inc;
          buf_d  = dbuf;
          if (done) begin
            pad_d = '0;
            buf_d = '0;
          end
          if (in_last_i) begin
            job_push_o     = 1'b1;
            job_o.kind     = JOB_ERR;
            job_o.last_idx = 2'd0;
            job_o.last     = 1'b1;
            buf_d          = '0;
            fill_d         = '0;
            pad_d          = '0;
            err_d          = 1'b0;
          end
        end else if (!done) begin
          fill_d = fill_inc;
          buf_d  = dbuf;
        end else begin
          job_push_o = 1'b1;
          buf_d      = '0;
          fill_d     = '0;
          pad_d      = '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      buf_q  <= '0;
      fill_q <= '0;
      pad_q  <= '0;
      err_q  <= 1'b0;
    end else begin
      buf_q  <= buf_d;
      fill_q <= fill_d;
      pad_q  <= pad_d;
      err_q  <= err_d;
    end
  end

endmodule

// ----- design/b64sc_fifo.sv -----
// ----------------------------------------------------------------------------
// b64sc_fifo
// Short job queue between the front and the back.
// ----------------------------------------------------------------------------
`include "base64_stream_codec_assert.svh"

module b64sc_fifo
  import b64sc_pkg::*;
#(
  parameter int unsigned Depth = QUEUE_DEPTH
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t data_i,
  input  logic pop_i,
  output job_t data_o,
  output logic full_o,
  output logic empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  job_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;

  assign full_o  = (count_q == CntW'(Depth));
  assign empty_o = (count_q == '0);
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push_i && !pop_i) begin
      count_d = count_q + CntW'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  `B64SC_NEVER(a_no_overflow, push_i && full_o && !pop_i, "job pushed into full queue")
  `B64SC_NEVER(a_no_underflow, pop_i && empty_o, "job popped from empty queue")
  `B64SC_ASSERT(a_count_up, push_i && !pop_i |=> count_q == $past(count_q) + CntW'(1), "count")

endmodule

// ----- design/b64sc_back.sv -----
// ----------------------------------------------------------------------------
// b64sc_back
// Expands queued jobs into result items via an output register, one per cycle unless stalled.
// ----------------------------------------------------------------------------
`include "base64_stream_codec_assert.svh"

module b64sc_back
  import b64sc_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  job_t       job_i,
  input  logic       job_valid_i,
  output logic       job_pop_o,
  output logic       m_tvalid_o,
  input  logic       m_tready_i,
  output logic [7:0] m_tdata_o,
  output logic       m_tlast_o,
  output logic       m_tuser_o
);

  logic [1:0] idx_q, idx_d;
  logic       vld_q, vld_d;
  logic [7:0] val_q, val_d;
  logic       last_q, last_d;
  logic       err_q, err_d;

  logic       load;
  logic       final_item;
  logic [5:0] six;
  logic [2:0] pad_pos;

  assign load       = job_valid_i && (!vld_q || m_tready_i);
  assign final_item = (idx_q == job_i.last_idx);
  assign job_pop_o  = load && final_item;
  assign pad_pos    = {1'b0, idx_q} + {1'b0, job_i.npad};

  always_comb begin
    case (idx_q)
      2'd0:    six = job_i.bits[23:18];
      2'd1:    six = job_i.bits[17:12];
      2'd2:    six = job_i.bits[11:6];
      default: six = job_i.bits[5:0];
    endcase
  end

  always_comb begin
    idx_d  = idx_q;
    vld_d  = vld_q && !m_tready_i;
    val_d  = val_q;
    last_d = last_q;
    err_d  = err_q;
    if (load) begin
      vld_d  = 1'b1;
      idx_d  = final_item ? 2'd0 : idx_q + 2'd1;
      last_d = job_i.last && final_item;
      err_d  = 1'b0;
      case (job_i.kind)
        JOB_ENC: val_d = (pad_pos > 3'd3) ? PAD_CHAR : b64_char(six);
        JOB_DEC: begin
          case (idx_q)
            2'd0:    val_d = job_i.bits[23:16];
            2'd1:    val_d = job_i.bits[15:8];
            default: val_d = job_i.bits[7:0];
          endcase
        end
        default: begin
          val_d  = 8'd0;
          last_d = 1'b1;
          err_d  = 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
      vld_q <= 1'b0;
    end else begin
      idx_q <= idx_d;
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q  <= val_d;
    last_q <= last_d;
    err_q  <= err_d;
  end

  assign m_tvalid_o = vld_q;
  assign m_tdata_o  = val_q;
  assign m_tlast_o  = last_q;
  assign m_tuser_o  = err_q;

  `B64SC_ASSERT(a_err_closes, vld_q && err_q |-> last_q && val_q == 8'd0, "error item not closing")

endmodule

// ----- design/base64_stream_codec.sv -----
// ----------------------------------------------------------------------------
// base64_stream_codec
// Base64 encoder/decoder on a stream, standard alphabet, APB mode register.
// ----------------------------------------------------------------------------
//  channel   direction  payload
//  s_axis    in         tdata[7:0] in_value, tlast in_last
//  m_axis    out        tdata[7:0] out_value, tlast out_last, tuser out_error
//  apb       in/out     reg 0 @ 0x0: decode_mode (bit 0)
//
//  One result item leaves per cycle from the back's output register while
//  m_axis_tready is high; the front takes one item per cycle while the
//  2-entry job queue has room. Encoding: 3 bytes -> 4 characters.
//  Decoding: 4 characters -> 3 bytes. Reset needs no clearing pass.
//  A stalled output fills the job queue, then holds s_axis_tready low.
// ----------------------------------------------------------------------------
module base64_stream_codec
  import b64sc_pkg::*;
#(
  parameter int unsigned QueueDepth = QUEUE_DEPTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] in_value
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [7:0] out_value
  output logic        m_axis_tlast,
  output logic        m_axis_tuser,   // [0] out_error
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic mode_q, mode_d;
  logic mode_wr;
  logic q_full, q_empty;
  logic job_push, job_pop;
  job_t job_in, job_out;

  assign pready  = 1'b1;
  assign mode_wr = psel && penable && pwrite && (paddr[2] == 1'b0);
  assign mode_d  = mode_wr ? pwdata[0] : mode_q;
  assign prdata  = (paddr[2] == 1'b0) ? {31'd0, mode_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b0;
    end else begin
      mode_q <= mode_d;
    end
  end

  b64sc_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .decode_mode_i(mode_q),
    .clear_i      (mode_wr),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .in_value_i   (s_axis_tdata),
    .in_last_i    (s_axis_tlast),
    .q_full_i     (q_full),
    .job_push_o   (job_push),
    .job_o        (job_in)
  );

  b64sc_fifo #(
    .Depth(QueueDepth)
  ) u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (job_push),
    .data_i (job_in),
    .pop_i  (job_pop),
    .data_o (job_out),
    .full_o (q_full),
    .empty_o(q_empty)
  );

  b64sc_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .job_i      (job_out),
    .job_valid_i(!q_empty),
    .job_pop_o  (job_pop),
    .m_tvalid_o (m_axis_tvalid),
    .m_tready_i (m_axis_tready),
    .m_tdata_o  (m_axis_tdata),
    .m_tlast_o  (m_axis_tlast),
    .m_tuser_o  (m_axis_tuser)
  );

endmodule
